// ----- rtl/gbom_pkg.sv -----
// Shared types and codes of the grouped box overlap matrix unit.
// Used by gbom_regs, gbom_ctrl, gbom_dp and the top level; depends on nothing.
package gbom_pkg;

  localparam int unsigned GRP_FIELD_W = 3;   // width of the group field
  localparam int unsigned NGRP_W      = 4;   // width of groups_in_use
  localparam int unsigned XY_W        = 16;  // width of box_x / box_y ports
  localparam int unsigned WH_W        = 15;  // width of box_w / box_h ports
  localparam int unsigned MASK_W      = 64;  // pair mask and hit matrix
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 64;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_EVAL  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic REG_PAIR_MASK = 1'b0;
  localparam logic REG_GROUPS    = 1'b1;

  localparam logic [NGRP_W-1:0] GROUPS_RESET = 4'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAIR,
    ST_ISSUE,
    ST_CMP,
    ST_NEXT,
    ST_RESP
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // latch status of the item being taken
    logic add;      // append the input box
    logic clear;    // empty groups and hit matrix
    logic rd;       // read box i of group a and box j of group b
    logic set_hit;  // set both hit bits of pair (a,b)
    logic emit;     // load the result registers
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic pair_en;
    logic a_empty;
    logic b_empty;
    logic i_last;
    logic j_last;
    logic overlap;
  } sts_t;

endpackage

// ----- rtl/gbom_regs.sv -----
// APB-style configuration registers: pair mask and groups in use.
// Depends on gbom_pkg.
module gbom_regs #(
  parameter int unsigned GROUPS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbom_pkg::APB_AW-1:0]   paddr,
  input  logic [gbom_pkg::APB_DW-1:0]   pwdata,
  output logic [gbom_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output logic [gbom_pkg::MASK_W-1:0]   pair_mask,
  output logic [gbom_pkg::NGRP_W-1:0]   groups_eff
);
  import gbom_pkg::*;

  logic [MASK_W-1:0] pair_mask_r;
  logic [NGRP_W-1:0] groups_r;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_mask_r <= '0;
      groups_r    <= GROUPS_RESET;
    end else if (wr_en) begin
      unique case (paddr[3])
        REG_PAIR_MASK: pair_mask_r <= pwdata;
        REG_GROUPS:    groups_r    <= pwdata[NGRP_W-1:0];
        default:       pair_mask_r <= pair_mask_r;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3])
      REG_PAIR_MASK: prdata = pair_mask_r;
      REG_GROUPS:    prdata = {{(APB_DW-NGRP_W){1'b0}}, groups_r};
      default:       prdata = '0;
    endcase
  end

  // saturate to the number of groups that exist
  assign pair_mask  = pair_mask_r;
  assign groups_eff = (groups_r > NGRP_W'(GROUPS)) ? NGRP_W'(GROUPS) : groups_r;

endmodule

// ----- rtl/gbom_dp.sv -----
// Datapath: box memory, per-group counts, overlap compare and hit matrix.
// Depends on gbom_pkg; driven by gbom_ctrl through cmd_t / sts_t.
module gbom_dp #(
  parameter int unsigned GROUPS          = 8,
  parameter int unsigned BOXES_PER_GROUP = 16,
  parameter int unsigned COORD_BITS      = 16,
  parameter int unsigned GW              = 3,
  parameter int unsigned IW              = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gbom_pkg::cmd_t                    cmd,
  output gbom_pkg::sts_t                    sts,
  input  logic [GW-1:0]                     grp_a,
  input  logic [GW-1:0]                     grp_b,
  input  logic [IW-1:0]                     idx_i,
  input  logic [IW-1:0]                     idx_j,
  input  logic [gbom_pkg::MASK_W-1:0]       pair_mask,
  input  logic [gbom_pkg::GRP_FIELD_W-1:0]  in_group,
  input  logic [gbom_pkg::XY_W-1:0]         in_box_x,
  input  logic [gbom_pkg::XY_W-1:0]         in_box_y,
  input  logic [gbom_pkg::WH_W-1:0]         in_box_w,
  input  logic [gbom_pkg::WH_W-1:0]         in_box_h,
  output logic                              out_status,
  output logic [gbom_pkg::MASK_W-1:0]       out_hit_bits
);
  import gbom_pkg::*;

  localparam int unsigned CNTW      = $clog2(BOXES_PER_GROUP + 1);
  localparam int unsigned AW        = GW + IW;
  localparam int unsigned DEPTH     = GROUPS << IW;
  localparam bit          SIGNED_IN = (COORD_BITS <= XY_W);
  localparam int unsigned SIGN_POS  = SIGNED_IN ? COORD_BITS - 1 : XY_W - 1;
  localparam int unsigned CVW       = SIGNED_IN ? COORD_BITS : XY_W + 1;
  localparam int unsigned EW        = ((CVW > XY_W) ? CVW : XY_W) + 1;
  localparam int unsigned BW        = 4 * EW;

  logic [BW-1:0]     mem [DEPTH];
  logic [BW-1:0]     rd_a_q;
  logic [BW-1:0]     rd_b_q;
  logic [CNTW-1:0]   cnt_r [GROUPS];
  logic [MASK_W-1:0] hit_r;
  logic              status_r;
  logic [MASK_W-1:0] out_hit_r;
  logic              out_status_r;

  logic              grp_ok;
  logic [GW-1:0]     wg;
  logic              wr_full;
  logic              add_drop;
  logic              add_we;
  logic [AW-1:0]     wr_addr;
  logic [EW-1:0]     left_e, top_e, right_e, bottom_e;
  logic [CNTW-1:0]   cnt_a, cnt_b;
  logic [2:0]        a3, b3;
  logic [MASK_W-1:0] set_mask;
  logic signed [EW-1:0] pl, pt, pr, pb, ql, qt, qr, qb;

  // sign-extend a raw coordinate from bit COORD_BITS-1 (zero-extend when COORD_BITS exceeds XY_W)
  function automatic logic [EW-1:0] coord_value(input logic [XY_W-1:0] raw);
    logic [EW-1:0] v;
    logic          s;
    s = SIGNED_IN ? raw[SIGN_POS] : 1'b0;
    for (int k = 0; k < EW; k++) begin
      v[k] = (k < XY_W && k < COORD_BITS) ? raw[k] : s;
    end
    return v;
  endfunction

  // add path
  assign grp_ok   = {1'b0, in_group} < NGRP_W'(GROUPS);
  assign wg       = in_group[GW-1:0];
  assign wr_full  = grp_ok ? (cnt_r[wg] >= CNTW'(BOXES_PER_GROUP)) : 1'b1;
  assign add_drop = wr_full;
  assign add_we   = cmd.add & ~add_drop;
  assign wr_addr  = {wg, cnt_r[wg][IW-1:0]};

  assign left_e   = coord_value(in_box_x);
  assign top_e    = coord_value(in_box_y);
  assign right_e  = left_e + EW'(in_box_w);
  assign bottom_e = top_e + EW'(in_box_h);

  always_ff @(posedge clk) begin
    if (add_we) begin
      mem[wr_addr] <= {bottom_e, right_e, top_e, left_e};
    end
    if (cmd.rd) begin
      rd_a_q <= mem[{grp_a, idx_i}];
      rd_b_q <= mem[{grp_b, idx_j}];
    end
  end

  // both symmetric bits of the current pair
  assign set_mask = (MASK_W'(1) << {a3, b3}) | (MASK_W'(1) << {b3, a3});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int g = 0; g < GROUPS; g++) cnt_r[g] <= '0;
      hit_r <= '0;
    end else if (cmd.clear) begin
      for (int g = 0; g < GROUPS; g++) cnt_r[g] <= '0;
      hit_r <= '0;
    end else begin
      if (add_we) cnt_r[wg] <= cnt_r[wg] + 1'b1;
      if (cmd.set_hit) hit_r <= hit_r | set_mask;
    end
  end

  // status of the item in flight, then the result registers
  always_ff @(posedge clk) begin
    if (cmd.accept) status_r <= cmd.add & add_drop;
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_hit_r    <= hit_r;
    end
  end

  assign out_status   = out_status_r;
  assign out_hit_bits = out_hit_r;

  // walk status
  assign a3    = 3'(grp_a);
  assign b3    = 3'(grp_b);
  assign cnt_a = cnt_r[grp_a];
  assign cnt_b = cnt_r[grp_b];

  assign pl = rd_a_q[EW-1:0];
  assign pt = rd_a_q[2*EW-1:EW];
  assign pr = rd_a_q[3*EW-1:2*EW];
  assign pb = rd_a_q[4*EW-1:3*EW];
  assign ql = rd_b_q[EW-1:0];
  assign qt = rd_b_q[2*EW-1:EW];
  assign qr = rd_b_q[3*EW-1:2*EW];
  assign qb = rd_b_q[4*EW-1:3*EW];

  always_comb begin
    sts.pair_en = pair_mask[{a3, b3}] | pair_mask[{b3, a3}];
    sts.a_empty = (cnt_a == '0);
    sts.b_empty = (cnt_b == '0);
    sts.i_last  = (CNTW'(idx_i) + 1'b1) == cnt_a;
    sts.j_last  = (CNTW'(idx_j) + 1'b1) == cnt_b;
    // strict overlap: touching edges give no hit
    sts.overlap = (pb > qt) && (pt < qb) && (pr > ql) && (pl < qr);
  end

endmodule

// ----- rtl/gbom_ctrl.sv -----
// Controller: item decode and the group-pair / box-pair walk sequencer.
// Depends on gbom_pkg; commands gbom_dp through cmd_t and reads sts_t.
module gbom_ctrl #(
  parameter int unsigned GW = 3,
  parameter int unsigned IW = 4
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [1:0]                  in_operation,
  input  logic [gbom_pkg::NGRP_W-1:0] groups_eff,
  input  gbom_pkg::sts_t              sts,
  output gbom_pkg::cmd_t              cmd,
  output logic                        busy,
  output logic                        out_valid,
  output logic [GW-1:0]               grp_a,
  output logic [GW-1:0]               grp_b,
  output logic [IW-1:0]               idx_i,
  output logic [IW-1:0]               idx_j
);
  import gbom_pkg::*;

  state_t        state_r, state_nxt;
  logic [GW-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [IW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic          valid_r;
  logic          self_pair;
  logic          b_end, a_end;

  assign self_pair = (a_r == b_r) && (i_r == j_r);
  assign b_end     = (NGRP_W'(b_r) + 1'b1) == groups_eff;
  assign a_end     = (NGRP_W'(a_r) + 1'b1) == groups_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
    i_r <= i_nxt;
    j_r <= j_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    a_nxt     = a_r;
    b_nxt     = b_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_RESP;
          a_nxt      = '0;
          b_nxt      = '0;
          unique case (in_operation)
            OP_ADD:   cmd.add   = 1'b1;
            OP_CLEAR: cmd.clear = 1'b1;
            OP_EVAL:  if (groups_eff != '0) state_nxt = ST_PAIR;
            default:  state_nxt = ST_RESP;
          endcase
        end
      end
      ST_PAIR: begin
        i_nxt = '0;
        j_nxt = '0;
        if (sts.pair_en && !sts.a_empty && !sts.b_empty) state_nxt = ST_ISSUE;
        else                                             state_nxt = ST_NEXT;
      end
      ST_ISSUE, ST_CMP: begin
        if (state_r == ST_ISSUE && !self_pair) begin
          cmd.rd    = 1'b1;
          state_nxt = ST_CMP;
        end else if (state_r == ST_CMP && sts.overlap) begin
          // one hit settles the pair
          cmd.set_hit = 1'b1;
          state_nxt   = ST_NEXT;
        end else if (sts.j_last) begin
          if (sts.i_last) begin
            state_nxt = ST_NEXT;
          end else begin
            i_nxt     = i_r + 1'b1;
            j_nxt     = '0;
            state_nxt = ST_ISSUE;
          end
        end else begin
          j_nxt     = j_r + 1'b1;
          state_nxt = ST_ISSUE;
        end
      end
      ST_NEXT: begin
        state_nxt = ST_PAIR;
        if (b_end) begin
          if (a_end) begin
            state_nxt = ST_RESP;
          end else begin
            a_nxt = a_r + 1'b1;
            b_nxt = a_r + 1'b1;
          end
        end else begin
          b_nxt = b_r + 1'b1;
        end
      end
      ST_RESP: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = valid_r;
  assign grp_a     = a_r;
  assign grp_b     = b_r;
  assign idx_i     = i_r;
  assign idx_j     = j_r;

endmodule

// ----- rtl/grouped_box_overlap_matrix_unit.sv -----
// Top level of the grouped box overlap matrix unit (AABB broad phase).
// Instantiates gbom_regs, gbom_ctrl and gbom_dp; depends on gbom_pkg.
//
// Items: drive in_* and raise start; the item is taken at the edge where start
//   is high and busy is low. busy stays high until the result is out.
// Results: one per item, on out_status / out_hit_bits for exactly one cycle with
//   out_valid high. The receiver cannot stall and must take the result in that
//   cycle. busy is already low then, so the next item may be taken meanwhile.
// Timing: add, clear and unused codes go from accept to ST_RESP, which loads the
//   result and raises out_valid; the next item can be taken once out_valid shows.
//   An evaluate walks each group pair through ST_PAIR and ST_NEXT, each box pair
//   compared through ST_ISSUE (memory read) and ST_CMP (compare), and skips each
//   self pair in ST_ISSUE; a pair stops at its first hit.
// Configuration: APB-style, pair_mask at 0x0, groups_in_use at 0x8, 64-bit
//   data, pready always high. Write only while idle.
// Reset (rst_n low, synchronous): groups empty, hit matrix zero, pair_mask
//   zero, groups_in_use 8. Box memory is not cleared; empty groups never read it.
module grouped_box_overlap_matrix_unit #(
  parameter int unsigned GROUPS          = 8,
  parameter int unsigned BOXES_PER_GROUP = 16,
  parameter int unsigned COORD_BITS      = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // item channel
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_operation,
  input  logic [gbom_pkg::GRP_FIELD_W-1:0]  in_group,
  input  logic signed [gbom_pkg::XY_W-1:0]  in_box_x,
  input  logic signed [gbom_pkg::XY_W-1:0]  in_box_y,
  input  logic [gbom_pkg::WH_W-1:0]         in_box_w,
  input  logic [gbom_pkg::WH_W-1:0]         in_box_h,
  // result channel
  output logic                              out_valid,
  output logic                              out_status,
  output logic [gbom_pkg::MASK_W-1:0]       out_hit_bits,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [gbom_pkg::APB_AW-1:0]       paddr,
  input  logic [gbom_pkg::APB_DW-1:0]       pwdata,
  output logic [gbom_pkg::APB_DW-1:0]       prdata,
  output logic                              pready
);
  import gbom_pkg::*;

  // group and box index widths; one bit minimum so a single group still works
  localparam int unsigned GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int unsigned IW = (BOXES_PER_GROUP > 1) ? $clog2(BOXES_PER_GROUP) : 1;

  logic [MASK_W-1:0] pair_mask;
  logic [NGRP_W-1:0] groups_eff;
  cmd_t              cmd;
  sts_t              sts;
  logic [GW-1:0]     grp_a, grp_b;
  logic [IW-1:0]     idx_i, idx_j;

  gbom_regs #(
    .GROUPS (GROUPS)
  ) u_regs (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .pair_mask  (pair_mask),
    .groups_eff (groups_eff)
  );

  gbom_ctrl #(
    .GW (GW),
    .IW (IW)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .in_operation (in_operation),
    .groups_eff   (groups_eff),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .out_valid    (out_valid),
    .grp_a        (grp_a),
    .grp_b        (grp_b),
    .idx_i        (idx_i),
    .idx_j        (idx_j)
  );

  gbom_dp #(
    .GROUPS          (GROUPS),
    .BOXES_PER_GROUP (BOXES_PER_GROUP),
    .COORD_BITS      (COORD_BITS),
    .GW              (GW),
    .IW              (IW)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .grp_a        (grp_a),
    .grp_b        (grp_b),
    .idx_i        (idx_i),
    .idx_j        (idx_j),
    .pair_mask    (pair_mask),
    .in_group     (in_group),
    .in_box_x     (in_box_x),
    .in_box_y     (in_box_y),
    .in_box_w     (in_box_w),
    .in_box_h     (in_box_h),
    .out_status   (out_status),
    .out_hit_bits (out_hit_bits)
  );

  // every accepted item raises busy in the following cycle, before its result
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("item accepted but block not busy");

  // results never come in two adjacent cycles
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  // a result is shown only once the block has finished its item
  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while item still at work");

endmodule
